// ===== src/variable_length_message_ring_macros.svh =====
// Assertion macros used by the checker file of the message ring.
`ifndef VARIABLE_LENGTH_MESSAGE_RING_MACROS_SVH
`define VARIABLE_LENGTH_MESSAGE_RING_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VLMR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VLMR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/vlmr_pkg.sv =====
// ----------------------------------------------------------------------------
// vlmr_pkg
// Types and constants shared by the variable-length message ring.
// ----------------------------------------------------------------------------
package vlmr_pkg;

  localparam int RING_BYTES_DEF = 4096;
  localparam int RING_AW_DEF    = 12;
  localparam int HDR_BYTES      = 6;
  localparam int CFG_W          = 13;
  localparam int SIZE_W         = 13;
  localparam int LEN_W          = 12;
  localparam int TYPE_W         = 16;
  localparam int DROP_W         = 10;
  localparam int CNT_W          = 32;
  localparam logic [7:0] MARK_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    CMD_PUSH_START,
    CMD_PUSH_DATA,
    CMD_POP_START,
    CMD_POP_DATA
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NO_SPACE,
    ST_EMPTY,
    ST_BAD_MARKER,
    ST_SEQ_ERR,
    ST_BAD_LEN
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_WALK_TEST,
    S_HDR,
    S_WALK_EVAL,
    S_POP_EVAL,
    S_MARK_CHK,
    S_MARK,
    S_HWR,
    S_DATA,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [TYPE_W-1:0] msg_type;
    logic [LEN_W-1:0]  msg_length;
    logic [7:0]        data_byte;
    logic              allow_overlap;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [TYPE_W-1:0] type_out;
    logic [LEN_W-1:0]  length_out;
    logic [7:0]        data_out;
    logic              last_byte;
    logic [DROP_W-1:0] dropped_count;
    logic              notify;
    logic [CNT_W-1:0]  msg_count;
    logic [SIZE_W-1:0] used_bytes;
    logic [SIZE_W-1:0] free_bytes;
  } out_word_t;

  typedef struct packed {
    logic              done;
    status_t           status;
    logic [TYPE_W-1:0] type_out;
    logic [LEN_W-1:0]  length_out;
    logic [7:0]        data_out;
    logic              last_byte;
    logic [DROP_W-1:0] dropped_count;
    logic              notify;
  } res_t;

endpackage

// ===== src/vlmr_ram.sv =====
// ----------------------------------------------------------------------------
// vlmr_ram
// Byte memory of the ring: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vlmr_ram import vlmr_pkg::*; #(
  parameter int DEPTH = RING_BYTES_DEF,
  parameter int AW    = RING_AW_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/vlmr_occ.sv =====
// ----------------------------------------------------------------------------
// vlmr_occ
// Occupancy of the ring: used bytes and largest contiguous free body size.
// ----------------------------------------------------------------------------
module vlmr_occ import vlmr_pkg::*; #(
  parameter int W = CFG_W
) (
  input  logic [W-1:0] ring,
  input  logic [W-1:0] push_pos,
  input  logic [W-1:0] pop_pos,
  input  logic         has_msgs,
  output logic [W-1:0] used,
  output logic [W-1:0] free
);

  localparam logic [W-1:0] HDR_W = W'(HDR_BYTES);

  logic         wrapped;
  logic [W-1:0] tail_room;
  logic [W-1:0] gap;

  always_comb begin
    wrapped   = (pop_pos >= push_pos) && has_msgs;
    tail_room = (push_pos <= ring) ? ring - push_pos : '0;
    if (wrapped) begin
      used = ring - pop_pos + push_pos;
      gap  = pop_pos - push_pos;
    end else begin
      used = (push_pos >= pop_pos) ? push_pos - pop_pos : '0;
      gap  = (tail_room < pop_pos) ? pop_pos : tail_room;
    end
    free = (gap < HDR_W) ? '0 : gap - HDR_W;
  end

endmodule

// ===== src/vlmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// vlmr_ctrl
// Command sequencer: cursors, counters and read-modify-write of the ring.
// ----------------------------------------------------------------------------
module vlmr_ctrl import vlmr_pkg::*; #(
  parameter int RING_BYTES = RING_BYTES_DEF,
  parameter int W          = CFG_W,
  parameter int AW         = RING_AW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [7:0]       mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic [7:0]       mem_rdata,
  input  logic [W-1:0]     free_bytes,
  output logic [W-1:0]     ring_size,
  output logic [W-1:0]     push_pos,
  output logic [W-1:0]     pop_pos,
  output logic [CNT_W-1:0] msg_count,
  output res_t             res
);

  localparam int LW  = (W > 16) ? W : 16;
  localparam int STW = $clog2(2 * RING_BYTES + 2);
  localparam logic [W-1:0]      RING_MAX = W'(RING_BYTES);
  localparam logic [W-1:0]      RING_MIN = W'(HDR_BYTES + 1);
  localparam logic [W-1:0]      HDR_W    = W'(HDR_BYTES);
  localparam logic [W:0]        HDR_W1   = (W+1)'(HDR_BYTES);
  localparam logic [STW-1:0]    STEP_MAX = STW'(2 * RING_BYTES);
  localparam logic [DROP_W-1:0] DROP_SAT = '1;

  state_t            state_r, state_nxt;
  in_word_t          in_r, in_nxt;
  logic [W-1:0]      ring_r, ring_nxt;
  logic [W-1:0]      push_r, push_nxt;
  logic [W-1:0]      pop_r, pop_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [W-1:0]      widx_r, widx_nxt;
  logic [W-1:0]      wrem_r, wrem_nxt;
  logic [W-1:0]      ridx_r, ridx_nxt;
  logic [W-1:0]      rrem_r, rrem_nxt;
  logic              push_open_r, push_open_nxt;
  logic              pop_open_r, pop_open_nxt;
  logic [W-1:0]      np_r, np_nxt;
  logic [W-1:0]      valid_r, valid_nxt;
  logic [STW-1:0]    steps_r, steps_nxt;
  logic [W-1:0]      base_r, base_nxt;
  logic [2:0]        hb_r, hb_nxt;
  logic              front_r, front_nxt;
  logic [7:0]        hdr_r [HDR_BYTES];
  logic [7:0]        hdr_nxt [HDR_BYTES];
  status_t           status_r, status_nxt;
  logic [TYPE_W-1:0] type_r, type_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [7:0]        data_r, data_nxt;
  logic              last_r, last_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic              note_r, note_nxt;

  logic         has;
  logic [W-1:0] msg_len_w;
  logic [W-1:0] m_w;
  logic         ok_c;
  logic         zpop_c;
  logic [W-1:0] np_c;
  logic [15:0]  hlen;
  logic         endm;
  logic [W-1:0] room;
  logic [W-1:0] step_w;
  logic [W-1:0] cfg_ext;
  logic [W-1:0] ring_cfg;
  logic [W-1:0] hdr_addr;
  logic [W-1:0] mark_addr;
  logic [W-1:0] hwr_addr;

  assign has       = cnt_r != '0;
  assign msg_len_w = W'(in_r.msg_length);
  assign m_w       = msg_len_w + HDR_W;
  assign hdr_addr  = base_r + W'(hb_r);
  assign mark_addr = push_r + W'(hb_r);
  assign hwr_addr  = np_r + W'(hb_r);

  assign ring_size = ring_r;
  assign push_pos  = push_r;
  assign pop_pos   = pop_r;
  assign msg_count = cnt_r;

  // Placement of a new message: behind the tail, at the front, or in the gap.
  always_comb begin
    ok_c   = 1'b0;
    zpop_c = 1'b0;
    np_c   = push_r;
    if (push_r > pop_r) begin
      if (({1'b0, push_r} + {1'b0, m_w}) > {1'b0, ring_r}) begin
        np_c = '0;
        ok_c = pop_r >= m_w;
      end else begin
        ok_c = 1'b1;
      end
    end else if ((push_r == pop_r) && !has) begin
      np_c   = '0;
      zpop_c = 1'b1;
      ok_c   = 1'b1;
    end else if ((push_r < pop_r) && ((pop_r - push_r) >= m_w)) begin
      ok_c = 1'b1;
    end else if ((push_r < pop_r) && ((ring_r - push_r) < m_w)) begin
      np_c = '0;
    end
  end

  // Header check: past the end, nonzero pad bytes or a length crossing the end is a marker.
  always_comb begin
    hlen   = {hdr_r[3], hdr_r[2]};
    room   = ring_r - HDR_W - base_r;
    endm   = (({1'b0, base_r} + HDR_W1) > {1'b0, ring_r}) ||
             (hdr_r[4] != 8'h00) || (hdr_r[5] != 8'h00) ||
             (LW'(hlen) > LW'(room));
    step_w = W'(hlen) + HDR_W;
  end

  always_comb begin
    cfg_ext  = W'(cfg_wdata);
    ring_cfg = (cfg_ext < RING_MIN) ? RING_MIN :
               ((cfg_ext > RING_MAX) ? RING_MAX : cfg_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ring_r      <= RING_MAX;
      push_r      <= '0;
      pop_r       <= '0;
      cnt_r       <= '0;
      widx_r      <= '0;
      wrem_r      <= '0;
      ridx_r      <= '0;
      rrem_r      <= '0;
      push_open_r <= 1'b0;
      pop_open_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ring_r      <= ring_nxt;
      push_r      <= push_nxt;
      pop_r       <= pop_nxt;
      cnt_r       <= cnt_nxt;
      widx_r      <= widx_nxt;
      wrem_r      <= wrem_nxt;
      ridx_r      <= ridx_nxt;
      rrem_r      <= rrem_nxt;
      push_open_r <= push_open_nxt;
      pop_open_r  <= pop_open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r     <= in_nxt;
    np_r     <= np_nxt;
    valid_r  <= valid_nxt;
    steps_r  <= steps_nxt;
    base_r   <= base_nxt;
    hb_r     <= hb_nxt;
    front_r  <= front_nxt;
    hdr_r    <= hdr_nxt;
    status_r <= status_nxt;
    type_r   <= type_nxt;
    len_r    <= len_nxt;
    data_r   <= data_nxt;
    last_r   <= last_nxt;
    drop_r   <= drop_nxt;
    note_r   <= note_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    ring_nxt      = ring_r;
    push_nxt      = push_r;
    pop_nxt       = pop_r;
    cnt_nxt       = cnt_r;
    widx_nxt      = widx_r;
    wrem_nxt      = wrem_r;
    ridx_nxt      = ridx_r;
    rrem_nxt      = rrem_r;
    push_open_nxt = push_open_r;
    pop_open_nxt  = pop_open_r;
    np_nxt        = np_r;
    valid_nxt     = valid_r;
    steps_nxt     = steps_r;
    base_nxt      = base_r;
    hb_nxt        = hb_r;
    front_nxt     = front_r;
    hdr_nxt       = hdr_r;
    status_nxt    = status_r;
    type_nxt      = type_r;
    len_nxt       = len_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    drop_nxt      = drop_r;
    note_nxt      = note_r;
    mem_we        = 1'b0;
    mem_waddr     = mark_addr[AW-1:0];
    mem_wdata     = MARK_BYTE;
    mem_raddr     = ridx_r[AW-1:0];
    busy          = state_r != S_IDLE;
    res.done          = 1'b0;
    res.status        = status_r;
    res.type_out      = type_r;
    res.length_out    = len_r;
    res.data_out      = data_r;
    res.last_byte     = last_r;
    res.dropped_count = drop_r;
    res.notify        = note_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt     = in_word;
          status_nxt = ST_OK;
          type_nxt   = '0;
          len_nxt    = '0;
          data_nxt   = '0;
          last_nxt   = 1'b0;
          drop_nxt   = '0;
          note_nxt   = 1'b0;
          state_nxt  = S_CMD;
        end
      end

      S_CMD: begin
        state_nxt = S_DONE;
        unique case (cmd_t'(in_r.command))
          CMD_PUSH_START: begin
            if (push_open_r) begin
              status_nxt = ST_SEQ_ERR;
            end else if (m_w > ring_r) begin
              status_nxt = ST_BAD_LEN;
            end else if (!in_r.allow_overlap && (free_bytes < msg_len_w)) begin
              status_nxt = ST_NO_SPACE;
            end else if (ok_c) begin
              if (zpop_c) begin
                pop_nxt = '0;
              end
              np_nxt    = np_c;
              state_nxt = S_MARK_CHK;
            end else if (in_r.allow_overlap) begin
              np_nxt    = np_c;
              valid_nxt = pop_r - np_c;
              steps_nxt = '0;
              state_nxt = S_WALK_TEST;
            end else begin
              status_nxt = ST_NO_SPACE;
            end
          end
          CMD_PUSH_DATA: begin
            if (!push_open_r) begin
              status_nxt = ST_SEQ_ERR;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = widx_r[AW-1:0];
              mem_wdata = in_r.data_byte;
              widx_nxt  = widx_r + W'(1);
              wrem_nxt  = wrem_r - W'(1);
              if (wrem_r == W'(1)) begin
                push_open_nxt = 1'b0;
                push_nxt      = widx_r + W'(1);
                cnt_nxt       = cnt_r + CNT_W'(1);
                note_nxt      = cnt_r == '0;
              end
            end
          end
          CMD_POP_START: begin
            if (pop_open_r) begin
              status_nxt = ST_SEQ_ERR;
            end else if (!has) begin
              status_nxt = ST_EMPTY;
            end else begin
              base_nxt  = pop_r;
              hb_nxt    = '0;
              front_nxt = 1'b0;
              state_nxt = S_HDR;
            end
          end
          CMD_POP_DATA: begin
            if (!pop_open_r) begin
              status_nxt = ST_SEQ_ERR;
            end else begin
              ridx_nxt  = ridx_r + W'(1);
              rrem_nxt  = rrem_r - W'(1);
              state_nxt = S_DATA;
              if (rrem_r == W'(1)) begin
                last_nxt     = 1'b1;
                pop_open_nxt = 1'b0;
                cnt_nxt      = cnt_r - CNT_W'(1);
                pop_nxt      = ridx_r + W'(1);
              end
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_WALK_TEST: begin
        if (valid_r >= m_w) begin
          state_nxt = S_MARK_CHK;
        end else if (!has || (steps_r > STEP_MAX)) begin
          cnt_nxt      = '0;
          pop_nxt      = '0;
          np_nxt       = '0;
          pop_open_nxt = 1'b0;
          state_nxt    = S_MARK_CHK;
        end else begin
          steps_nxt = steps_r + STW'(1);
          base_nxt  = pop_r;
          hb_nxt    = '0;
          state_nxt = S_HDR;
        end
      end

      S_HDR: begin
        mem_raddr = hdr_addr[AW-1:0];
        if (hb_r != 3'd0) begin
          hdr_nxt[hb_r - 3'd1] = mem_rdata;
        end
        if (hb_r == 3'(HDR_BYTES)) begin
          state_nxt = (in_r.command == CMD_POP_START) ? S_POP_EVAL : S_WALK_EVAL;
        end else begin
          hb_nxt = hb_r + 3'd1;
        end
      end

      S_WALK_EVAL: begin
        state_nxt = S_WALK_TEST;
        if (endm) begin
          pop_nxt   = '0;
          np_nxt    = '0;
          valid_nxt = '0;
        end else begin
          pop_nxt      = base_r + step_w;
          cnt_nxt      = cnt_r - CNT_W'(1);
          valid_nxt    = valid_r + step_w;
          pop_open_nxt = 1'b0;
          if (drop_r != DROP_SAT) begin
            drop_nxt = drop_r + DROP_W'(1);
          end
        end
      end

      S_POP_EVAL: begin
        state_nxt = S_DONE;
        if (endm && !front_r) begin
          pop_nxt   = '0;
          base_nxt  = '0;
          hb_nxt    = '0;
          front_nxt = 1'b1;
          state_nxt = S_HDR;
        end else if (endm) begin
          status_nxt = ST_BAD_MARKER;
        end else begin
          type_nxt     = {hdr_r[1], hdr_r[0]};
          len_nxt      = LEN_W'(hlen);
          ridx_nxt     = base_r + HDR_W;
          rrem_nxt     = W'(hlen);
          pop_open_nxt = 1'b1;
          if (hlen == 16'd0) begin
            pop_open_nxt = 1'b0;
            cnt_nxt      = cnt_r - CNT_W'(1);
            pop_nxt      = base_r + HDR_W;
          end
        end
      end

      S_MARK_CHK: begin
        hb_nxt    = '0;
        state_nxt = S_HWR;
        if (push_r != np_r) begin
          if (({1'b0, push_r} + HDR_W1) <= {1'b0, ring_r}) begin
            state_nxt = S_MARK;
          end else begin
            push_nxt = np_r;
          end
        end
      end

      S_MARK: begin
        mem_we = 1'b1;
        if (hb_r == 3'(HDR_BYTES - 1)) begin
          push_nxt  = np_r;
          hb_nxt    = '0;
          state_nxt = S_HWR;
        end else begin
          hb_nxt = hb_r + 3'd1;
        end
      end

      S_HWR: begin
        mem_we    = 1'b1;
        mem_waddr = hwr_addr[AW-1:0];
        case (hb_r)
          3'd0:    mem_wdata = in_r.msg_type[7:0];
          3'd1:    mem_wdata = in_r.msg_type[15:8];
          3'd2:    mem_wdata = in_r.msg_length[7:0];
          3'd3:    mem_wdata = 8'(in_r.msg_length >> 8);
          default: mem_wdata = 8'h00;
        endcase
        if (hb_r == 3'(HDR_BYTES - 1)) begin
          widx_nxt      = np_r + HDR_W;
          wrem_nxt      = msg_len_w;
          push_open_nxt = 1'b1;
          state_nxt     = S_DONE;
          if (in_r.msg_length == '0) begin
            push_open_nxt = 1'b0;
            push_nxt      = np_r + HDR_W;
            cnt_nxt       = cnt_r + CNT_W'(1);
            note_nxt      = cnt_r == '0;
          end
        end else begin
          hb_nxt = hb_r + 3'd1;
        end
      end

      S_DATA: begin
        data_nxt  = mem_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        res.done  = 1'b1;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // A register write empties the ring.
    if (cfg_we) begin
      ring_nxt      = ring_cfg;
      push_nxt      = '0;
      pop_nxt       = '0;
      cnt_nxt       = '0;
      widx_nxt      = '0;
      wrem_nxt      = '0;
      ridx_nxt      = '0;
      rrem_nxt      = '0;
      push_open_nxt = 1'b0;
      pop_open_nxt  = 1'b0;
    end
  end

endmodule

// ===== src/variable_length_message_ring.sv =====
// ----------------------------------------------------------------------------
// variable_length_message_ring
// Byte ring of variable-length messages with a 6-byte header each.
// ----------------------------------------------------------------------------
//
//   channel   ports                        handshake
//   input     start, busy, in_word         word taken when start & !busy
//   result    out_strobe, out_word         one cycle per word, no back-pressure
//   config    cfg_we, cfg_wdata            ring_size written when cfg_we
//
// Each word yields exactly one result word, shown for one cycle on the first
// cycle that busy is low again. pop_start reads the header one byte per
// cycle, and reads it again from the front of the ring when it meets an
// end marker. push_start either rejects the message or writes its header,
// first stamping an end marker over the old tail when it moves to the
// front. In overlap mode it first walks and drops the oldest messages until
// there is room. Reset is synchronous; the receiver cannot stall.
//
module variable_length_message_ring import vlmr_pkg::*; #(
  parameter int RING_BYTES = RING_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_strobe,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // Cursor width covers both the ring depth and the 13-bit size register.
  localparam int PW = $clog2(RING_BYTES + 1);
  localparam int W  = (PW > CFG_W) ? PW : CFG_W;
  localparam int AW = $clog2(RING_BYTES);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;
  logic [W-1:0]     free_w;
  logic [W-1:0]     used_w;
  logic [W-1:0]     ring_size;
  logic [W-1:0]     push_pos;
  logic [W-1:0]     pop_pos;
  logic [CNT_W-1:0] msg_count;
  res_t             res;
  logic             out_strobe_r;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;

  // The ring body lives entirely in this memory.
  vlmr_ram #(
    .DEPTH(RING_BYTES),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Used and free bytes follow the live cursors; the sequencer uses the free
  // figure for its no-space check, and the result word reports both.
  vlmr_occ #(
    .W(W)
  ) u_occ (
    .ring    (ring_size),
    .push_pos(push_pos),
    .pop_pos (pop_pos),
    .has_msgs(msg_count != '0),
    .used    (used_w),
    .free    (free_w)
  );

  vlmr_ctrl #(
    .RING_BYTES(RING_BYTES),
    .W         (W),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .free_bytes(free_w),
    .ring_size (ring_size),
    .push_pos  (push_pos),
    .pop_pos   (pop_pos),
    .msg_count (msg_count),
    .res       (res)
  );

  // The result word is assembled when the sequencer finishes, at which point
  // every cursor and counter already holds its post-command value.
  always_comb begin
    out_word_nxt.status        = res.status;
    out_word_nxt.type_out      = res.type_out;
    out_word_nxt.length_out    = res.length_out;
    out_word_nxt.data_out      = res.data_out;
    out_word_nxt.last_byte     = res.last_byte;
    out_word_nxt.dropped_count = res.dropped_count;
    out_word_nxt.notify        = res.notify;
    out_word_nxt.msg_count     = msg_count;
    out_word_nxt.used_bytes    = used_w[SIZE_W-1:0];
    out_word_nxt.free_bytes    = free_w[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res.done;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// ===== src/vlmr_chk.sv =====
// ----------------------------------------------------------------------------
// vlmr_chk
// Port-level checks of the message ring, bound to the top level.
// ----------------------------------------------------------------------------
`include "variable_length_message_ring_macros.svh"

module vlmr_chk import vlmr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_word_t out_word
);

  `VLMR_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `VLMR_ASSERT_IMP(a_done_strobe, $fell(busy), out_strobe, "busy fell without a result")
  `VLMR_ASSERT_IMP(a_notify_one, out_strobe && out_word.notify, out_word.msg_count == 32'd1, "notify with count other than one")
  `VLMR_ASSERT_IMP(a_last_ok, out_strobe && out_word.last_byte, out_word.status == ST_OK, "last byte on a failed command")

endmodule

bind variable_length_message_ring vlmr_chk u_chk (.*);
